// ----- src/spq_pkg.sv -----
// Shared types and codes for the stable priority queue core.
// Used by the queue store, the top level and the port checker; depends on nothing.
package spq_pkg;

  localparam int TAG_W  = 16;
  localparam int PRIO_W = 2;
  localparam int FILL_W = 5;

  // One stored entry: priority above tag, as held in the slot memory.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

endpackage

// ----- src/spq_store.sv -----
// Ring-addressed slot memory of the stable priority queue core.
// Maps logical slot numbers onto physical addresses from the head pointer; uses spq_pkg.
module spq_store #(
  parameter int QUEUE_DEPTH = 16,
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic            clk,
  input  logic [PW-1:0]   head,
  input  logic [PW-1:0]   rd_idx,
  input  logic            wr_en,
  input  logic [PW-1:0]   wr_idx,
  input  spq_pkg::entry_t wr_data,
  output spq_pkg::entry_t rd_data
);

  spq_pkg::entry_t mem [QUEUE_DEPTH];
  spq_pkg::entry_t rd_data_r;
  logic [PW-1:0]   rd_addr;
  logic [PW-1:0]   wr_addr;

  // Logical slot to physical address; the sum stays below twice the depth.
  function automatic logic [PW-1:0] ring_addr(input logic [PW-1:0] base,
                                              input logic [PW-1:0] idx);
    logic [PW:0] sum;
    sum = {1'b0, base} + {1'b0, idx};
    if (sum >= (PW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (PW+1)'(QUEUE_DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  assign rd_addr = ring_addr(head, rd_idx);
  assign wr_addr = ring_addr(head, wr_idx);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/stable_priority_queue_core.sv -----
// Top level of the stable priority queue core: handshakes, sequencer and result register.
// Instantiates spq_store; uses spq_pkg.
//
// A bounded priority queue held in sorted order, front first, with first in, first out
// order among entries of equal priority. Each input word is one command: an insert
// (in_tuser low) places the tag and priority from in_tdata behind every stored entry of
// equal or higher priority, and a remove (in_tuser high) takes out the front entry. Each
// command gives exactly one output word carrying the front entry and fill count after the
// command, with a status in out_tuser: done, insert dropped because the queue is full, or
// remove ignored because the queue is empty. The entries live in a single-port-write,
// registered-read slot memory addressed as a ring, so a remove only moves the head
// pointer, then reads the new front before the result goes to the output register. An
// insert walks from the tail towards the front, one compare-and-move per cycle through
// the memory's read port, moving each stored entry of lower priority back one slot, then
// writes the new entry and reads the front. A dropped insert skips the walk and the
// write, and a remove on an empty queue skips the front read too. The input is not ready
// while a command is in progress; it is ready again as soon as the result has gone into
// the output register, even if that word has not yet been taken. The memory needs no
// clearing after reset: only slots below the fill count are ever used.
module stable_priority_queue_core #(
  parameter int QUEUE_DEPTH = 16,
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // tag [15:0], priority_req [17:16], zero [23:18]
  input  logic [0:0]  in_tuser,  // cmd [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // front_valid [0], front_tag [16:1],
                                 // front_priority [18:17], fill_count [23:19]
  output logic [1:0]  out_tuser  // status [1:0]
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CMP   = 5'b00010,
    S_WR    = 5'b00100,
    S_FRONT = 5'b01000,
    S_RES   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [PW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  spq_pkg::entry_t   new_r, new_nxt;
  spq_pkg::status_t  status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [23:0]       out_data_r, out_data_nxt;
  logic [1:0]        out_user_r, out_user_nxt;

  logic              in_acc;
  logic              res_load;
  logic [CW-1:0]     rd_slot;
  logic [PW-1:0]     rd_idx;
  logic              wr_en;
  logic [PW-1:0]     wr_idx;
  spq_pkg::entry_t   wr_data;
  spq_pkg::entry_t   rd_data;
  spq_pkg::entry_t   front;
  logic [31:0]       count_ext;

  spq_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk    (clk),
    .head   (head_r),
    .rd_idx (rd_idx),
    .wr_en  (wr_en),
    .wr_idx (wr_idx),
    .wr_data(wr_data),
    .rd_data(rd_data)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign rd_idx    = rd_slot[PW-1:0];
  assign wr_idx    = k_r[PW-1:0];

  // The output register is free when empty or when its word leaves in this cycle.
  assign res_load  = (state_r == S_RES) && (!out_valid_r || out_tready);

  // An empty queue reports a zero front entry.
  assign front     = (count_r == '0) ? '0 : rd_data;
  assign count_ext = 32'(count_r);

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    k_nxt      = k_r;
    new_nxt    = new_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    wr_data    = rd_data;
    // Idle: prefetch the tail slot, which is what an insert compares first.
    rd_slot    = count_r - CW'(1);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          new_nxt.tag  = in_tdata[15:0];
          new_nxt.prio = in_tdata[17:16];
          status_nxt   = spq_pkg::STAT_DONE;
          if (in_tuser[0] == spq_pkg::CMD_INSERT) begin
            if (count_r == CW'(QUEUE_DEPTH)) begin
              status_nxt = spq_pkg::STAT_FULL;
              state_nxt  = S_FRONT;
            end else if (count_r == '0) begin
              k_nxt     = '0;
              state_nxt = S_WR;
            end else begin
              k_nxt     = count_r;
              state_nxt = S_CMP;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = spq_pkg::STAT_EMPTY;
              state_nxt  = S_RES;
            end else begin
              head_nxt  = (head_r == PW'(QUEUE_DEPTH - 1)) ? '0 : head_r + PW'(1);
              count_nxt = count_r - CW'(1);
              state_nxt = S_FRONT;
            end
          end
        end
      end

      S_CMP: begin
        // rd_data holds slot k-1. A lower priority entry moves back into slot k.
        rd_slot = k_r - CW'(2);
        if (rd_data.prio < new_r.prio) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          k_nxt   = k_r - CW'(1);
          if (k_r == CW'(1)) begin
            state_nxt = S_WR;
          end
        end else begin
          state_nxt = S_WR;
        end
      end

      S_WR: begin
        wr_en     = 1'b1;
        wr_data   = new_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_FRONT;
      end

      S_FRONT: begin
        rd_slot   = '0;
        state_nxt = S_RES;
      end

      S_RES: begin
        // Keep reading the front so that it stays put while the output is stalled.
        rd_slot = '0;
        if (res_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {count_ext[spq_pkg::FILL_W-1:0], front.prio, front.tag,
                       (count_r != '0)};
      out_user_nxt  = status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    new_r      <= new_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- src/spq_checker.sv -----
// Port-level checks for the stable priority queue core, bound to the top level.
// Sees the top level's ports only; uses spq_pkg for the status codes.
module spq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // Every command leaves the idle state, so the input drops after an accepted word.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready straight after an accepted word");

  // An empty queue reports a zero front entry and a zero fill count.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[23:1] == 23'd0)
    else $error("empty queue with non-zero front or fill count");

  // A full-drop status means the queue holds entries; an empty-remove means it holds none.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == spq_pkg::STAT_DONE) ||
                   ((out_tuser == spq_pkg::STAT_FULL) && out_tdata[0]) ||
                   ((out_tuser == spq_pkg::STAT_EMPTY) && !out_tdata[0]))
    else $error("status inconsistent with front");

endmodule

bind stable_priority_queue_core spq_checker u_spq_checker (.*);

// ----- sim/tb_stable_priority_queue_core.sv -----
// Self-checking testbench for stable_priority_queue_core: directed table, then random commands.
// Depends on spq_pkg and the core's RTL only; needs no files or arguments at run time.
`timescale 1ns / 100ps

module tb_stable_priority_queue_core;

  localparam int QUEUE_DEPTH = 16;
  localparam int RANDOM_WORDS = 600;
  localparam int PHASE_WORDS = RANDOM_WORDS / 3;
  localparam int TAG_W  = spq_pkg::TAG_W;
  localparam int PRIO_W = spq_pkg::PRIO_W;
  localparam int FILL_W = spq_pkg::FILL_W;

  // One expected output word, split into the fields carried by out_tdata and out_tuser.
  typedef struct packed {
    logic              front_valid;
    logic [TAG_W-1:0]  front_tag;
    logic [PRIO_W-1:0] front_prio;
    logic [FILL_W-1:0] fill;
    spq_pkg::status_t  status;
  } front_report_t;

  // One row of the directed table. A row with a repeat count above one sends that many
  // commands, adding the repeat index to the tag so that the order of equal priorities
  // stays visible. A typed report is only given on single rows.
  typedef struct {
    logic              cmd;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    int                reps;
    bit                typed;
    front_report_t     want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // tag [15:0], priority_req [17:16], zero [23:18]
  logic [0:0]  in_tuser;   // cmd [0]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // front_valid [0], front_tag [16:1],
                           // front_priority [18:17], fill_count [23:19]
  logic [1:0]  out_tuser;  // status [1:0]

  // Our own copy of the queue, front first, and the reports still owed by the core.
  spq_pkg::entry_t sorted_entries[$];
  front_report_t   expected_fronts[$];
  stim_row_t       directed_rows[$];

  // Chance in a hundred, per cycle, that the sender or the receiver holds back.
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int          mismatches = 0;

  stable_priority_queue_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Generous overall limit: the slowest legal run is well under a tenth of this.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Applies one command to the local queue and returns the report the core should give.
  // An insert goes behind every entry of equal or higher priority, so a higher priority
  // than the present front takes the front, and equal priorities leave in arrival order.
  function automatic front_report_t apply_command(logic cmd, logic [TAG_W-1:0] tag,
                                                  logic [PRIO_W-1:0] prio);
    front_report_t   r;
    spq_pkg::entry_t e;
    int              pos;
    r = '0;
    r.status = spq_pkg::STAT_DONE;
    if (cmd == spq_pkg::CMD_INSERT) begin
      if (sorted_entries.size() >= QUEUE_DEPTH) begin
        r.status = spq_pkg::STAT_FULL;
      end else begin
        pos = 0;
        while (pos < sorted_entries.size() && sorted_entries[pos].prio >= prio) pos++;
        e.tag  = tag;
        e.prio = prio;
        sorted_entries.insert(pos, e);
      end
    end else if (sorted_entries.size() == 0) begin
      r.status = spq_pkg::STAT_EMPTY;
    end else begin
      void'(sorted_entries.pop_front());
    end
    if (sorted_entries.size() != 0) begin
      r.front_valid = 1'b1;
      r.front_tag   = sorted_entries[0].tag;
      r.front_prio  = sorted_entries[0].prio;
    end
    r.fill = FILL_W'(sorted_entries.size());
    return r;
  endfunction

  task automatic add_row(logic cmd, logic [TAG_W-1:0] tag, logic [PRIO_W-1:0] prio,
                         int reps, bit typed, front_report_t want);
    stim_row_t row;
    row.cmd   = cmd;
    row.tag   = tag;
    row.prio  = prio;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Called just after a rising edge. Idles at random, presents the word and waits for the
  // handshake; the report is predicted at the edge that accepts the word.
  task automatic send_command(logic cmd, logic [TAG_W-1:0] tag, logic [PRIO_W-1:0] prio,
                              bit typed, front_report_t want);
    front_report_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'b0, prio, tag};
    do @(posedge clk); while (!in_tready);
    predicted = apply_command(cmd, tag, prio);
    expected_fronts.push_back(typed ? want : predicted);
  endtask

  // Drops tvalid and holds off until the core has returned every owed report. At least
  // one edge passes so that tvalid is never lowered and raised in the same step.
  task automatic drain_reports();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_fronts.size() != 0);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // The receiver decides afresh each cycle whether to take a word.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Every accepted output word is checked against the oldest owed report.
  always @(posedge clk) begin
    front_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_fronts.size() == 0) begin
        $display("%0t: unexpected word, tdata %h tuser %h", $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = expected_fronts.pop_front();
        check_field("front_valid", 32'(want.front_valid), 32'(out_tdata[0]));
        check_field("front_tag", 32'(want.front_tag), 32'(out_tdata[16:1]));
        check_field("front_priority", 32'(want.front_prio), 32'(out_tdata[18:17]));
        check_field("fill_count", 32'(want.fill), 32'(out_tdata[23:19]));
        check_field("status", 32'(want.status), 32'(out_tuser));
      end
    end
  end

  initial begin
    logic              cmd;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    int unsigned       insert_pct;
    front_report_t     no_report;

    no_report    = '0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    src_idle_pct = 24;
    snk_idle_pct = 59;

    // Remove on an empty queue straight after reset must be ignored and flagged.
    add_row(spq_pkg::CMD_REMOVE, 16'h0000, 2'd0, 1, 1'b1,
            front_report_t'{1'b0, 16'h0000, 2'd0, 5'd0, spq_pkg::STAT_EMPTY});
    add_row(spq_pkg::CMD_INSERT, 16'h0000, 2'd0, 1, 1'b1,
            front_report_t'{1'b1, 16'h0000, 2'd0, 5'd1, spq_pkg::STAT_DONE});
    // A higher priority than the front must take the front; an equal one goes behind it.
    add_row(spq_pkg::CMD_INSERT, 16'hFFFF, 2'd3, 1, 1'b0, no_report);
    add_row(spq_pkg::CMD_INSERT, 16'h1234, 2'd3, 1, 1'b0, no_report);
    add_row(spq_pkg::CMD_INSERT, 16'hAAAA, 2'd1, 1, 1'b0, no_report);
    add_row(spq_pkg::CMD_INSERT, 16'h5555, 2'd2, 1, 1'b0, no_report);
    add_row(spq_pkg::CMD_REMOVE, 16'hFFFF, 2'd3, 5, 1'b0, no_report);
    add_row(spq_pkg::CMD_REMOVE, 16'h0000, 2'd0, 1, 1'b1,
            front_report_t'{1'b0, 16'h0000, 2'd0, 5'd0, spq_pkg::STAT_EMPTY});
    // Fill to the brim in mixed priority groups, then an insert into a full queue.
    add_row(spq_pkg::CMD_INSERT, 16'h8000, 2'd0, 4, 1'b0, no_report);
    add_row(spq_pkg::CMD_INSERT, 16'h8100, 2'd2, 4, 1'b0, no_report);
    add_row(spq_pkg::CMD_INSERT, 16'h8200, 2'd1, 4, 1'b0, no_report);
    add_row(spq_pkg::CMD_INSERT, 16'h8300, 2'd3, 4, 1'b0, no_report);
    add_row(spq_pkg::CMD_INSERT, 16'h9999, 2'd3, 1, 1'b0, no_report);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      for (int k = 0; k < directed_rows[i].reps; k++) begin
        send_command(directed_rows[i].cmd, directed_rows[i].tag + TAG_W'(k),
                     directed_rows[i].prio, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Hold the sender back until the directed reports are all in.
    drain_reports();

    // Random commands in blocks of forty, each block with its own insert bias, so the
    // queue swings between empty and full and both special cases keep recurring.
    insert_pct = 50;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == PHASE_WORDS) begin
        drain_reports();
        src_idle_pct = 59;
        snk_idle_pct = 24;
      end else if (n == 2 * PHASE_WORDS) begin
        drain_reports();
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (n % 40 == 0) begin
        case ($urandom_range(3))
          0: begin
            insert_pct = 25;
          end
          1: begin
            insert_pct = 50;
          end
          2: begin
            insert_pct = 75;
          end
          default: begin
            insert_pct = 90;
          end
        endcase
      end
      cmd  = ($urandom_range(99) < insert_pct) ? spq_pkg::CMD_INSERT : spq_pkg::CMD_REMOVE;
      prio = PRIO_W'($urandom_range(3));
      case ($urandom_range(15))
        0: begin
          tag = 16'h0000;
        end
        1: begin
          tag = 16'hFFFF;
        end
        default: begin
          tag = TAG_W'($urandom_range(16'hFFFF));
        end
      endcase
      send_command(cmd, tag, prio, 1'b0, no_report);
    end

    drain_reports();
    // Give the core time to show any stray word after the last report.
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- stable_priority_queue_core.f -----
src/spq_pkg.sv
src/spq_store.sv
src/stable_priority_queue_core.sv
src/spq_checker.sv
sim/tb_stable_priority_queue_core.sv
